// ===== src/bprq_pkg.sv =====
// package for the bitmap priority ready queue
// widths, command and status codes, state machine states; no dependencies
package bprq_pkg;
    localparam int LEVELS    = 32;
    localparam int MAX_TASKS = 64;
    localparam int NUM_CPUS  = 8;
    localparam int TW = 6;
    localparam int LW = 5;
    localparam int NW = 7;   // link width, MAX_TASKS means no neighbor
    localparam logic [NW-1:0] NIL = NW'(MAX_TASKS);

    typedef enum logic [2:0] {
        CMD_ENQ_TAIL = 3'd0,
        CMD_ENQ_HEAD = 3'd1,
        CMD_REMOVE   = 3'd2,
        CMD_PEEK     = 3'd3,
        CMD_POP      = 3'd4,
        CMD_COUNT    = 3'd5
    } cmd_t;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_QUEUED     = 2'd1;
    localparam logic [1:0] ST_NOT_QUEUED = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_LINK, S_UNRD, S_UNLINK, S_UNHD,
        S_LVL, S_WALK, S_WCHK, S_DONE
    } state_t;
endpackage

// ===== src/bitmap_priority_ready_queue_top.sv =====
// bitmap priority ready queue: linked lists of task ids per priority level
// uses bprq_pkg; all list state lies in task and level memories
//
// usage: one command word in on s_axis, one result word out on m_axis.
// s_axis_tdata (lowest bit up): command[2:0], task_id[8:3],
//   priority_req[13:9], task_affinity[21:14], cpu_id[24:22]
// m_axis_tdata (lowest bit up): result_task[5:0], found[6],
//   level_count[13:7], status[15:14]
// one command is worked at a time by a sequencer over synchronous memories
// with registered reads. enqueue patches a neighbor unless its level is
// empty; remove unlinks the task; peek scans levels from level 0; count
// walks the tasks on the level; pop scans levels, walks the tasks of each
// nonempty level and unlinks the first task whose affinity matches.
// the result word sits in an output register; the next command is taken
// once the result has been accepted or while it is being accepted.
// reset clears the level bitmap and the queued flags (flip-flops); the link,
// head, tail, priority and affinity memories need no clearing.
// a stalled receiver holds the result word and blocks new commands.
module bitmap_priority_ready_queue_top
    import bprq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // command, task_id, priority_req, task_affinity, cpu_id
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // result_task, found, level_count, status
);
    // memories
    logic [NW-1:0] next_mem [MAX_TASKS];
    logic [NW-1:0] prev_mem [MAX_TASKS];
    logic [LW-1:0] prio_mem [MAX_TASKS];
    logic [7:0]    aff_mem  [MAX_TASKS];
    logic [TW-1:0] head_mem [LEVELS];
    logic [TW-1:0] tail_mem [LEVELS];

    logic [LEVELS-1:0]    busy_reg;     // bit l set when level l nonempty
    logic [MAX_TASKS-1:0] queued_reg;
    state_t state_reg, state_next;

    logic [2:0]    cmd_reg;
    logic [TW-1:0] tid_reg;
    logic [LW-1:0] lvl_reg;
    logic [7:0]    aff_reg;
    logic [2:0]    cpu_reg;
    logic [NW-1:0] cur_reg;
    logic [6:0]    cnt_reg;
    logic          ovalid_reg;
    logic [15:0]   odata_reg;

    // registered read data
    logic [NW-1:0] rd_next, rd_prev;
    logic [LW-1:0] rd_prio;
    logic [7:0]    rd_aff;
    logic [TW-1:0] rd_head, rd_tail;
    logic [TW-1:0] t_addr;
    logic [LW-1:0] l_addr;

    // memory ports: one read address per memory group, writes from the fsm
    logic          wn_en, wp_en, wt_en, wh_en, wl_en;
    logic [TW-1:0] wn_a, wp_a, wt_a;
    logic [NW-1:0] wn_d, wp_d;
    logic [LW-1:0] wh_a, wl_a;
    logic [TW-1:0] wh_d, wl_d;

    always_ff @(posedge aclk) begin
        rd_next <= next_mem[t_addr];
        rd_prev <= prev_mem[t_addr];
        rd_prio <= prio_mem[t_addr];
        rd_aff  <= aff_mem[t_addr];
        rd_head <= head_mem[l_addr];
        rd_tail <= tail_mem[l_addr];
        if (wn_en) next_mem[wn_a] <= wn_d;
        if (wp_en) prev_mem[wp_a] <= wp_d;
        if (wt_en) begin
            prio_mem[wt_a] <= lvl_reg;
            aff_mem[wt_a]  <= aff_reg;
        end
        if (wh_en) head_mem[wh_a] <= wh_d;
        if (wl_en) tail_mem[wl_a] <= wl_d;
    end

    logic out_free;
    assign out_free      = !ovalid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

    logic take;
    assign take = s_axis_tvalid && s_axis_tready;

    logic          cpu_ok;
    logic          lvl_busy;
    logic          cur_ok;
    logic          pop_first;    // unlinked task had no predecessor
    logic [NW-1:0] un_prev, un_next;
    logic [NW-1:0] un_prev_reg, un_next_reg;
    logic [LW-1:0] un_lvl_reg;

    assign lvl_busy = busy_reg[lvl_reg];
    assign cpu_ok   = (NUM_CPUS == 1) || rd_aff[cpu_reg];
    assign un_prev  = rd_prev;
    assign un_next  = rd_next;
    assign pop_first = un_prev_reg[NW-1];
    assign cur_ok   = cpu_ok;

    logic       done_en;
    logic [15:0] done_d;
    logic       busy_set, busy_clr, q_set, q_clr;
    logic [LW-1:0] busy_a;
    logic [TW-1:0] q_a;
    logic [NW-1:0] cur_next;
    logic [LW-1:0] lvl_next;
    logic [6:0]    cnt_next;
    logic          un_cap;

    // sequencer
    always_comb begin
        state_next = state_reg;
        t_addr = tid_reg; l_addr = lvl_reg;
        wn_en = 1'b0; wp_en = 1'b0; wt_en = 1'b0; wh_en = 1'b0; wl_en = 1'b0;
        wn_a = tid_reg; wp_a = tid_reg; wt_a = tid_reg;
        wn_d = NIL; wp_d = NIL; wh_a = lvl_reg; wl_a = lvl_reg;
        wh_d = tid_reg; wl_d = tid_reg;
        done_en = 1'b0; done_d = '0;
        busy_set = 1'b0; busy_clr = 1'b0; busy_a = lvl_reg;
        q_set = 1'b0; q_clr = 1'b0; q_a = tid_reg;
        cur_next = cur_reg; lvl_next = lvl_reg; cnt_next = cnt_reg;
        un_cap = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (take) state_next = S_RD;
            end
            S_RD: begin
                // addresses already on tid/lvl; this state waits for the registered read data
                case (cmd_reg)
                    CMD_ENQ_TAIL, CMD_ENQ_HEAD: begin
                        if (queued_reg[tid_reg]) begin
                            done_en = 1'b1; done_d = {ST_QUEUED, 14'd0};
                            state_next = S_IDLE;
                        end else begin
                            state_next = S_LINK;
                        end
                    end
                    CMD_REMOVE: begin
                        if (!queued_reg[tid_reg]) begin
                            done_en = 1'b1; done_d = {ST_NOT_QUEUED, 14'd0};
                            state_next = S_IDLE;
                        end else begin
                            state_next = S_UNRD;
                        end
                    end
                    CMD_PEEK, CMD_POP: begin
                        lvl_next = '0;
                        state_next = S_LVL;
                    end
                    CMD_COUNT: begin
                        cnt_next = '0;
                        state_next = S_LVL;
                    end
                    default: begin
                        done_en = 1'b1; state_next = S_IDLE;
                    end
                endcase
            end
            S_LINK: begin
                wt_en = 1'b1; q_set = 1'b1;
                state_next = S_DONE;
                if (!lvl_busy) begin
                    wn_en = 1'b1; wp_en = 1'b1; wh_en = 1'b1; wl_en = 1'b1;
                    busy_set = 1'b1;
                    // empty level: no neighbor to patch
                    done_en = 1'b1; state_next = S_IDLE;
                end else if (cmd_reg == CMD_ENQ_HEAD) begin
                    wp_en = 1'b1; wp_d = NIL; wh_en = 1'b1;
                    wn_en = 1'b1; wn_d = {1'b0, rd_head};
                end else begin
                    wn_en = 1'b1; wn_d = NIL; wl_en = 1'b1;
                    wp_en = 1'b1; wp_d = {1'b0, rd_tail};
                end
            end
            S_DONE: begin
                // second write of an enqueue at a nonempty level
                if (lvl_busy && cmd_reg == CMD_ENQ_HEAD) begin
                    wp_en = 1'b1; wp_a = rd_head; wp_d = {1'b0, tid_reg};
                end else if (lvl_busy && cmd_reg == CMD_ENQ_TAIL) begin
                    wn_en = 1'b1; wn_a = rd_tail; wn_d = {1'b0, tid_reg};
                end
                done_en = 1'b1; state_next = S_IDLE;
            end
            S_UNRD: begin
                // task links and priority are valid now
                un_cap = 1'b1;
                state_next = S_UNLINK;
            end
            S_UNLINK: begin
                q_clr = 1'b1;
                if (!un_prev_reg[NW-1]) begin
                    wn_en = 1'b1; wn_a = un_prev_reg[TW-1:0]; wn_d = un_next_reg;
                end else begin
                    wh_en = 1'b1; wh_a = un_lvl_reg; wh_d = un_next_reg[TW-1:0];
                end
                if (!un_next_reg[NW-1]) begin
                    wp_en = 1'b1; wp_a = un_next_reg[TW-1:0]; wp_d = un_prev_reg;
                end else begin
                    wl_en = 1'b1; wl_a = un_lvl_reg; wl_d = un_prev_reg[TW-1:0];
                end
                if (pop_first && un_next_reg[NW-1]) begin
                    busy_clr = 1'b1; busy_a = un_lvl_reg;
                end
                done_en = 1'b1;
                done_d = (cmd_reg == CMD_POP) ? {ST_OK, 7'd0, 1'b1, tid_reg}
                                              : 16'd0;
                state_next = S_IDLE;
            end
            S_LVL: begin
                // head of lvl_reg is read now; the read data is valid in S_UNHD
                state_next = S_UNHD;
            end
            S_UNHD: begin
                if (cmd_reg == CMD_COUNT) begin
                    if (!lvl_busy) begin
                        done_en = 1'b1; state_next = S_IDLE;
                    end else begin
                        cur_next = {1'b0, rd_head}; state_next = S_WALK;
                    end
                end else if (!lvl_busy) begin
                    if (lvl_reg == LW'(LEVELS - 1)) begin
                        done_en = 1'b1; state_next = S_IDLE;
                    end else begin
                        lvl_next = lvl_reg + 1'b1; state_next = S_LVL;
                    end
                end else if (cmd_reg == CMD_PEEK) begin
                    done_en = 1'b1; done_d = {ST_OK, 7'd0, 1'b1, rd_head};
                    state_next = S_IDLE;
                end else begin
                    cur_next = {1'b0, rd_head}; state_next = S_WALK;
                end
            end
            S_WALK: begin
                t_addr = cur_reg[TW-1:0];
                state_next = S_WCHK;
            end
            S_WCHK: begin
                t_addr = cur_reg[TW-1:0];
                if (cmd_reg == CMD_COUNT) begin
                    if (cur_ok && cnt_reg != 7'd127) cnt_next = cnt_reg + 1'b1;
                    cur_next = rd_next;
                    if (rd_next[NW-1]) begin
                        done_en = 1'b1;
                        done_d = {ST_OK, (cur_ok && cnt_reg != 7'd127)
                                  ? cnt_reg + 7'd1 : cnt_reg, 7'd0};
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_WALK;
                    end
                end else if (cur_ok) begin
                    un_cap = 1'b1;
                    state_next = S_UNLINK;
                end else if (!rd_next[NW-1]) begin
                    cur_next = rd_next; state_next = S_WALK;
                end else if (lvl_reg == LW'(LEVELS - 1)) begin
                    done_en = 1'b1; state_next = S_IDLE;
                end else begin
                    lvl_next = lvl_reg + 1'b1; state_next = S_LVL;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and bookkeeping registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            busy_reg   <= '0;
            queued_reg <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (busy_set) busy_reg[busy_a] <= 1'b1;
            if (busy_clr) busy_reg[busy_a] <= 1'b0;
            if (q_set) queued_reg[q_a] <= 1'b1;
            if (q_clr) queued_reg[q_a] <= 1'b0;
            if (done_en) ovalid_reg <= 1'b1;
            else if (m_axis_tready) ovalid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (take) begin
            cmd_reg <= s_axis_tdata[2:0];
            tid_reg <= s_axis_tdata[8:3];
            lvl_reg <= s_axis_tdata[13:9];
            aff_reg <= s_axis_tdata[21:14];
            cpu_reg <= s_axis_tdata[24:22];
        end else begin
            lvl_reg <= lvl_next;
        end
        if (state_reg == S_WCHK && cur_ok && cmd_reg == CMD_POP)
            tid_reg <= cur_reg[TW-1:0];
        if (state_reg == S_UNRD) un_lvl_reg <= rd_prio;
        if (state_reg == S_WCHK) un_lvl_reg <= lvl_reg;
        if (un_cap) begin
            un_prev_reg <= un_prev;
            un_next_reg <= un_next;
        end
        cur_reg <= cur_next;
        cnt_reg <= cnt_next;
        if (done_en) odata_reg <= done_d;
    end
endmodule

// ===== tb/bitmap_priority_ready_queue_top_tb.sv =====
// testbench for the bitmap priority ready queue: command words in, result words checked
// against a behavioral queue model kept in the bench; depends on bprq_pkg and the top level
module bitmap_priority_ready_queue_top_tb;
    import bprq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] level_count;
        logic       found;
        logic [5:0] result_task;
    } result_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    bitmap_priority_ready_queue_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // queue model: per-level fifos of task ids
    int           lvl_fifo[LEVELS][$];
    logic [4:0]   task_lvl[MAX_TASKS];
    logic [7:0]   task_aff[MAX_TASKS];
    bit           task_on[MAX_TASKS];
    result_word_t pending_results[$];

    int  error_count;
    int  cycle_count = 0;
    bit  sender_gaps;
    bit  receiver_stalls;
    localparam int CYCLE_LIMIT = 1000000;

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bitmap_priority_ready_queue_top_tb: FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    function automatic bit cpu_match(input int t, input logic [2:0] cpu);
        if (NUM_CPUS == 1) return 1'b1;
        if (cpu >= NUM_CPUS) return 1'b0;
        return task_aff[t][cpu];
    endfunction

    // predict the result of one command word and update the model
    function automatic result_word_t predict_queue_op(input logic [2:0] cmd,
            input logic [5:0] tid, input logic [4:0] prio,
            input logic [7:0] aff, input logic [2:0] cpu);
        result_word_t r;
        int n;
        int lv;
        r = '0;
        n = 0;
        case (cmd)
            CMD_ENQ_TAIL, CMD_ENQ_HEAD: begin
                if (task_on[tid]) r.status = ST_QUEUED;
                else begin
                    task_on[tid] = 1'b1;
                    task_lvl[tid] = prio;
                    task_aff[tid] = aff;
                    if (cmd == CMD_ENQ_HEAD) lvl_fifo[prio].push_front(tid);
                    else lvl_fifo[prio].push_back(tid);
                end
            end
            CMD_REMOVE: begin
                if (!task_on[tid]) r.status = ST_NOT_QUEUED;
                else begin
                    lv = task_lvl[tid];
                    for (int i = 0; i < lvl_fifo[lv].size(); i++)
                        if (lvl_fifo[lv][i] == tid) n = i;
                    lvl_fifo[lv].delete(n);
                    task_on[tid] = 1'b0;
                end
            end
            CMD_PEEK: begin
                for (int l = 0; l < LEVELS && !r.found; l++)
                    if (lvl_fifo[l].size() > 0) begin
                        r.found = 1'b1;
                        r.result_task = lvl_fifo[l][0];
                    end
            end
            CMD_POP: begin
                for (int l = 0; l < LEVELS && !r.found; l++)
                    for (int i = 0; i < lvl_fifo[l].size() && !r.found; i++)
                        if (cpu_match(lvl_fifo[l][i], cpu)) begin
                            r.found = 1'b1;
                            r.result_task = lvl_fifo[l][i];
                            task_on[lvl_fifo[l][i]] = 1'b0;
                            lvl_fifo[l].delete(i);
                        end
            end
            CMD_COUNT: begin
                for (int i = 0; i < lvl_fifo[prio].size(); i++)
                    if (cpu_match(lvl_fifo[prio][i], cpu)) n++;
                r.level_count = (n > 127) ? 7'd127 : 7'(n);
            end
            default: ;
        endcase
        return r;
    endfunction

    // send one command word, with an optional random gap before it
    task automatic send_word(input logic [2:0] cmd, input logic [5:0] tid,
            input logic [4:0] prio, input logic [7:0] aff, input logic [2:0] cpu);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, cpu, aff, prio, tid, cmd};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        pending_results.push_back(predict_queue_op(cmd, tid, prio, aff, cpu));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() > 0) @(posedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        result_word_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.result_task !== want.result_task)
                    report_mismatch("result_task", got.result_task, want.result_task);
                if (got.found !== want.found)
                    report_mismatch("found", got.found, want.found);
                if (got.level_count !== want.level_count)
                    report_mismatch("level_count", got.level_count, want.level_count);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
            end
        end
    end

    // receiver stalls in bursts
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (receiver_stalls && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic test_directed();
        send_word(CMD_PEEK, 0, 0, 0, 0);            // empty queue
        send_word(CMD_POP, 0, 0, 0, 3);
        send_word(CMD_REMOVE, 63, 0, 0, 0);         // not queued
        send_word(CMD_ENQ_TAIL, 0, 31, 8'hff, 0);
        send_word(CMD_ENQ_TAIL, 63, 31, 8'h80, 0);
        send_word(CMD_ENQ_HEAD, 5, 31, 8'h01, 0);
        send_word(CMD_ENQ_TAIL, 0, 3, 8'hff, 0);    // already queued
        send_word(CMD_ENQ_HEAD, 9, 0, 8'h00, 0);
        send_word(CMD_COUNT, 0, 31, 0, 7);
        send_word(CMD_COUNT, 0, 31, 0, 0);
        send_word(CMD_COUNT, 0, 17, 0, 0);          // empty level
        send_word(CMD_PEEK, 0, 0, 0, 0);
        send_word(CMD_POP, 0, 0, 0, 7);             // skips affinity-free task
        send_word(CMD_POP, 0, 0, 0, 6);             // no match
        send_word(CMD_REMOVE, 9, 0, 0, 0);
        send_word(CMD_REMOVE, 5, 0, 0, 0);
        send_word(3'd6, 6'h3f, 5'h1f, 8'hff, 3'h7); // unused codes
        send_word(3'd7, 0, 0, 0, 0);
        send_word(CMD_POP, 0, 0, 0, 0);
        send_word(CMD_PEEK, 0, 0, 0, 0);
        wait_drained();
    endtask

    // random sequences over task ids 0 to tid_max; a small set makes collisions and deep lists occur
    task automatic test_random(input int items, input int tid_max);
        logic [2:0] cmd;
        int k;
        for (int i = 0; i < items; i++) begin
            k = $urandom_range(0, 99);
            if (k < 30) cmd = CMD_ENQ_TAIL;
            else if (k < 45) cmd = CMD_ENQ_HEAD;
            else if (k < 60) cmd = CMD_REMOVE;
            else if (k < 68) cmd = CMD_PEEK;
            else if (k < 85) cmd = CMD_POP;
            else if (k < 97) cmd = CMD_COUNT;
            else cmd = 3'($urandom_range(6, 7));
            send_word(cmd, 6'($urandom_range(0, tid_max)),
                      5'($urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                   : $urandom_range(0, 3)),
                      8'($urandom), 3'($urandom));
        end
    endtask

    task automatic test_pause_drain();
        test_random(40, 63);
        wait_drained();
        test_random(20, 15);
    endtask

    initial begin
        error_count     = 0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        aresetn         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(250, 15);
        test_pause_drain();
        test_random(150, 63);
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        test_random(120, 20);
        wait_drained();
        repeat (50) @(posedge aclk);
        if (error_count == 0)
            $display("bitmap_priority_ready_queue_top_tb: PASS");
        else
            $display("bitmap_priority_ready_queue_top_tb: FAIL");
        $finish;
    end
endmodule
